// ----- hw/rtl/decimal_numeral_parser_assert.svh -----
// ----------------------------------------------------------------------------
// Decimal numeral parser assertion macros
// Concurrent assertion helpers that are compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_NUMERAL_PARSER_ASSERT_SVH
`define DECIMAL_NUMERAL_PARSER_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clock and disabled during reset.
`define DNP_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dnp: same-cycle check failed");
// Next-cycle implication, sampled on clock and disabled during reset.
`define DNP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dnp: next-cycle check failed");
`else
`define DNP_ASSERT_IMP(label, ante, cons)
`define DNP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- hw/rtl/dnp_pkg.sv -----
// ----------------------------------------------------------------------------
// Decimal numeral parser package
// Shared item types, register indexes, status codes and character constants.
// ----------------------------------------------------------------------------
`default_nettype none

package dnp_pkg;

   // Field widths fixed by the item formats.
   localparam int CH_WIDTH       = 8;
   localparam int MAG_WIDTH      = 64;
   localparam int MANT_WIDTH     = 64;
   localparam int COUNT_WIDTH    = 5;
   localparam int STATUS_WIDTH   = 2;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH = 5;

   // Defaults for the top-level parameters.
   localparam int ACC_WIDTH_DEFAULT           = 64;
   localparam int MAX_FRACTION_DIGITS_DEFAULT = 19;

   // Register reset values.
   localparam logic                   FRACTION_ENABLE_RESET = 1'b1;
   localparam logic [COUNT_WIDTH-1:0] FRACTION_LIMIT_RESET  = 5'd19;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_FRACTION_ENABLE = 2'd0,
      CSR_FRACTION_LIMIT  = 2'd1
   } csr_index_type;

   // Result status codes.
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_NO_DIGIT = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_NO_FRAC  = 2'd2;

   // ASCII characters the parser reacts to.
   localparam logic [CH_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CH_WIDTH-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CH_WIDTH-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CH_WIDTH-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CH_WIDTH-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CH_WIDTH-1:0] CHAR_POINT = 8'h2E;

   // One input item: a character and the end-of-buffer flag.
   typedef struct packed {
      logic [CH_WIDTH-1:0] ch;
      logic                last;
   } req_item_type;

   // One result item.
   typedef struct packed {
      logic                    negative;
      logic [MAG_WIDTH-1:0]    integer_magnitude;
      logic [MANT_WIDTH-1:0]   fraction_mantissa;
      logic [COUNT_WIDTH-1:0]  fraction_count;
      logic [STATUS_WIDTH-1:0] status;
   } rsp_item_type;

   // Input stage to parse core: the held item and its valid flag.
   typedef struct packed {
      logic         valid;
      req_item_type item;
   } stage_type;

endpackage

`default_nettype wire

// ----- hw/rtl/decimal_numeral_parser.sv -----
// ----------------------------------------------------------------------------
// Decimal numeral parser
// Parses a signed ASCII decimal number, one character per item.
// ----------------------------------------------------------------------------
// The parser takes one character every clock cycle while input is not
// stalled. Each accepted item is held in an input register, then the state
// machine and the times-ten accumulators advance and, on a buffer's last
// character, the result register is loaded. The accumulate loop (two shifts
// and a 64-bit add) sets the clock rate; a waiting result stalls input only
// when the next buffer's last character reaches the core. Write the
// configuration registers only while no item is held in the parser and no
// result waits to be taken.
`default_nettype none

module decimal_numeral_parser #(
   parameter int ACC_WIDTH           = dnp_pkg::ACC_WIDTH_DEFAULT,
   parameter int MAX_FRACTION_DIGITS = dnp_pkg::MAX_FRACTION_DIGITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire dnp_pkg::req_item_type               req_item,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output dnp_pkg::rsp_item_type                    rsp_item,
   input  wire logic                                csr_wen,
   input  wire logic [dnp_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  wire logic [dnp_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import dnp_pkg::*;

   logic                   fraction_enable_ff;
   logic [COUNT_WIDTH-1:0] fraction_limit_ff;
   stage_type              stage;
   logic                   advance;

   // Configuration registers; writes to unused indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         fraction_enable_ff <= FRACTION_ENABLE_RESET;
         fraction_limit_ff  <= FRACTION_LIMIT_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_FRACTION_ENABLE: fraction_enable_ff <= csr_wdata[0];
            CSR_FRACTION_LIMIT:  fraction_limit_ff  <= csr_wdata[COUNT_WIDTH-1:0];
            default: begin
               fraction_enable_ff <= fraction_enable_ff;
            end
         endcase
      end
   end

   // Input register.
   dnp_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .advance   (advance),
      .stage     (stage)
   );

   // Parse state machine and result register.
   dnp_parse_core #(
      .ACC_WIDTH           (ACC_WIDTH),
      .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
   ) u_parse_core (
      .clock           (clock),
      .reset           (reset),
      .stage           (stage),
      .advance         (advance),
      .fraction_enable (fraction_enable_ff),
      .fraction_limit  (fraction_limit_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_item        (rsp_item)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/dnp_in_stage.sv -----
// ----------------------------------------------------------------------------
// Decimal numeral parser input stage
// Registers one accepted item and holds it until the parse core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dnp_in_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire dnp_pkg::req_item_type req_item,
   input  wire logic                 advance,
   output dnp_pkg::stage_type        stage
);
   import dnp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   // A new item enters when the stage is empty or drains in this cycle.
   assign req_ready = !valid_ff || advance;

   always_comb begin
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/dnp_parse_core.sv -----
// ----------------------------------------------------------------------------
// Decimal numeral parser core
// Per-character state machine, accumulators and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "decimal_numeral_parser_assert.svh"

module dnp_parse_core #(
   parameter int ACC_WIDTH           = dnp_pkg::ACC_WIDTH_DEFAULT,
   parameter int MAX_FRACTION_DIGITS = dnp_pkg::MAX_FRACTION_DIGITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire dnp_pkg::stage_type                   stage,
   output logic                                      advance,
   input  wire logic                                 fraction_enable,
   input  wire logic [dnp_pkg::COUNT_WIDTH-1:0]      fraction_limit,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output dnp_pkg::rsp_item_type                     rsp_item
);
   import dnp_pkg::*;

   typedef enum logic [2:0] {
      PH_SPACE = 3'd0,
      PH_SIGN  = 3'd1,
      PH_INT   = 3'd2,
      PH_POINT = 3'd3,
      PH_FRAC  = 3'd4,
      PH_DONE  = 3'd5,
      PH_ERROR = 3'd6
   } phase_type;

   localparam logic [COUNT_WIDTH-1:0] MAX_DIGITS = COUNT_WIDTH'(MAX_FRACTION_DIGITS);

   // Parse state.
   phase_type               phase_ff, phase_in;
   logic                    minus_ff, minus_in;
   logic [ACC_WIDTH-1:0]    int_acc_ff, int_acc_in;
   logic [MANT_WIDTH-1:0]   frac_acc_ff, frac_acc_in;
   logic [COUNT_WIDTH-1:0]  frac_cnt_ff, frac_cnt_in;
   logic [STATUS_WIDTH-1:0] err_ff, err_in;

   // Result register.
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_item_type            rsp_item_ff, rsp_item_in;

   logic                    fire;
   logic                    is_digit;
   logic [3:0]              digit;
   logic [ACC_WIDTH-1:0]    int_step;
   logic [MANT_WIDTH-1:0]   frac_step;
   logic [COUNT_WIDTH-1:0]  limit_eff;
   logic [STATUS_WIDTH-1:0] status;
   logic [CH_WIDTH-1:0]     ch;

   // A held item moves on unless it ends a buffer while a result waits untaken.
   assign advance = stage.valid &&
                    (!stage.item.last || !rsp_valid_ff || rsp_ready);
   assign fire    = advance;
   assign ch      = stage.item.ch;

   // Digit decode and the times-ten accumulate as two shifts and an add.
   assign is_digit  = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
   assign digit     = is_digit ? ch[3:0] : 4'd0;
   assign int_step  = (int_acc_ff << 3) + (int_acc_ff << 1) + ACC_WIDTH'(digit);
   assign frac_step = (frac_acc_ff << 3) + (frac_acc_ff << 1) + MANT_WIDTH'(digit);
   assign limit_eff = (fraction_limit > MAX_DIGITS) ? MAX_DIGITS : fraction_limit;

   // Next state for the character held in the input stage.
   always_comb begin
      phase_in    = phase_ff;
      minus_in    = minus_ff;
      int_acc_in  = int_acc_ff;
      frac_acc_in = frac_acc_ff;
      frac_cnt_in = frac_cnt_ff;
      err_in      = err_ff;
      case (phase_ff)
         PH_SPACE: begin
            if (ch == CHAR_SPACE) begin
               phase_in = PH_SPACE;
            end else if (ch == CHAR_MINUS) begin
               minus_in = 1'b1;
               phase_in = PH_SIGN;
            end else if (ch == CHAR_PLUS) begin
               phase_in = PH_SIGN;
            end else if (is_digit) begin
               int_acc_in = ACC_WIDTH'(digit);
               phase_in   = PH_INT;
            end else begin
               err_in   = STATUS_NO_DIGIT;
               phase_in = PH_ERROR;
            end
         end
         PH_SIGN: begin
            if (is_digit) begin
               int_acc_in = ACC_WIDTH'(digit);
               phase_in   = PH_INT;
            end else begin
               err_in   = STATUS_NO_DIGIT;
               phase_in = PH_ERROR;
            end
         end
         PH_INT: begin
            if (is_digit) begin
               int_acc_in = int_step;
            end else if (ch == CHAR_POINT && fraction_enable) begin
               phase_in = PH_POINT;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_POINT: begin
            if (is_digit) begin
               if (limit_eff != '0) begin
                  frac_acc_in = MANT_WIDTH'(digit);
                  frac_cnt_in = COUNT_WIDTH'(1);
               end
               phase_in = PH_FRAC;
            end else begin
               err_in   = STATUS_NO_FRAC;
               phase_in = PH_ERROR;
            end
         end
         PH_FRAC: begin
            if (is_digit && frac_cnt_ff < limit_eff) begin
               frac_acc_in = frac_step;
               frac_cnt_in = frac_cnt_ff + COUNT_WIDTH'(1);
            end else begin
               phase_in = PH_DONE;
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // Status and result fields taken from the state after the last character.
   always_comb begin
      case (phase_in)
         PH_SPACE: status = STATUS_NO_DIGIT;
         PH_SIGN:  status = STATUS_NO_DIGIT;
         PH_POINT: status = STATUS_NO_FRAC;
         PH_ERROR: status = err_in;
         default:  status = STATUS_OK;
      endcase
      if (status == STATUS_OK) begin
         rsp_item_in.negative          = minus_in;
         rsp_item_in.integer_magnitude = MAG_WIDTH'(int_acc_in);
         rsp_item_in.fraction_mantissa = frac_acc_in;
         rsp_item_in.fraction_count    = frac_cnt_in;
      end else begin
         rsp_item_in.negative          = 1'b0;
         rsp_item_in.integer_magnitude = '0;
         rsp_item_in.fraction_mantissa = '0;
         rsp_item_in.fraction_count    = '0;
      end
      rsp_item_in.status = status;
   end

   // The result register fills on a last item and empties when taken.
   always_comb begin
      if (fire && stage.item.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State and result registers; a last item returns the parser to its start.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SPACE;
         minus_ff     <= 1'b0;
         int_acc_ff   <= '0;
         frac_acc_ff  <= '0;
         frac_cnt_ff  <= '0;
         err_ff       <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            if (stage.item.last) begin
               phase_ff    <= PH_SPACE;
               minus_ff    <= 1'b0;
               int_acc_ff  <= '0;
               frac_acc_ff <= '0;
               frac_cnt_ff <= '0;
               err_ff      <= STATUS_OK;
               rsp_item_ff <= rsp_item_in;
            end else begin
               phase_ff    <= phase_in;
               minus_ff    <= minus_in;
               int_acc_ff  <= int_acc_in;
               frac_acc_ff <= frac_acc_in;
               frac_cnt_ff <= frac_cnt_in;
               err_ff      <= err_in;
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // A character that does not end a buffer never raises a result.
   `DNP_ASSERT_NEXT(a_no_result_mid_buffer, fire && !stage.item.last && !rsp_valid_ff, !rsp_valid_ff)
   // A buffer's last character always leaves a result waiting.
   `DNP_ASSERT_NEXT(a_result_on_last, fire && stage.item.last, rsp_valid_ff)
   // After a buffer ends the parser is back at its starting state.
   `DNP_ASSERT_NEXT(a_restart_after_last, fire && stage.item.last, phase_ff == PH_SPACE && int_acc_ff == '0 && frac_cnt_ff == '0)
   // While still skipping spaces nothing has been gathered.
   `DNP_ASSERT_IMP(a_space_is_clean, phase_ff == PH_SPACE, int_acc_ff == '0 && !minus_ff && err_ff == STATUS_OK)
   // An error result carries no number.
   `DNP_ASSERT_IMP(a_error_fields_zero, rsp_valid_ff && rsp_item_ff.status != STATUS_OK, !rsp_item_ff.negative && rsp_item_ff.integer_magnitude == '0 && rsp_item_ff.fraction_count == '0)

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// Decimal numeral parser testbench
// Drives character buffers through the parser with random idle cycles on both
// sides, predicts each result with a scan model of its own or takes it typed
// from the directed table, and compares each result field by field. A table
// of directed buffers comes first, followed by random well-formed numerals,
// broken numerals and noise under several fraction settings.
// ----------------------------------------------------------------------------
module testbench;
   import dnp_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 10;
   localparam int RANDOM_ITEMS  = 400;
   localparam int MAX_GAP       = 11;
   localparam int LONG_HOLD     = 80;
   localparam int SETTLE_CYCLES = 6;
   localparam int STALL_LIMIT   = 1000;
   localparam int FRACTION_CAP  = MAX_FRACTION_DIGITS_DEFAULT;

   // Directed rows either carry a result typed in or leave it to the scan model.
   localparam bit TYPED          = 1'b1;
   localparam bit FROM_PREDICTOR = 1'b0;

   // Where the scan model stands within the current buffer.
   typedef enum logic [2:0] {
      SCAN_SPACE,
      SCAN_SIGN,
      SCAN_INT,
      SCAN_POINT,
      SCAN_FRAC,
      SCAN_DONE,
      SCAN_ERROR
   } scan_phase_type;

   typedef bit [CH_WIDTH-1:0] char_queue_type[$];

   // One directed buffer with the settings it runs under.
   typedef struct {
      bit                     fraction_on;
      logic [COUNT_WIDTH-1:0] fraction_limit;
      string                  text;
      bit                     typed;
      rsp_item_type           result;
   } numeral_case_type;

   // Result written into the directed table, used in place of the prediction.
   typedef struct packed {
      bit           typed;
      rsp_item_type result;
   } known_result_type;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_item_type              req_item  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_item_type              rsp_item;
   logic                      csr_wen   = 1'b0;
   logic [CSR_IDX_WIDTH-1:0]  csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   // Scan model state and its copy of the registers.
   scan_phase_type            scan_phase         = SCAN_SPACE;
   bit                        minus_flag         = 1'b0;
   logic [MAG_WIDTH-1:0]      int_total          = '0;
   logic [MANT_WIDTH-1:0]     frac_total         = '0;
   logic [COUNT_WIDTH-1:0]    frac_digits        = '0;
   logic [STATUS_WIDTH-1:0]   scan_error         = STATUS_OK;
   bit                        cfg_fraction_on    = FRACTION_ENABLE_RESET;
   logic [COUNT_WIDTH-1:0]    cfg_fraction_limit = FRACTION_LIMIT_RESET;

   rsp_item_type              expected_results[$];
   known_result_type          known_results[$];
   numeral_case_type          directed_cases[$];

   bit sender_busy       = 1'b0;
   bit receiver_busy     = 1'b0;
   bit long_hold_pending = 1'b0;
   int chars_sent        = 0;
   int buffers_sent      = 0;
   int results_checked   = 0;
   int settings_used     = 0;
   int mismatch_count    = 0;
   int quiet_cycles      = 0;

   decimal_numeral_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Advances the scan model by one character; returns 1 with the result when
   // the character closes its buffer.
   function automatic bit scan_char(input req_item_type it, output rsp_item_type outcome);
      bit                     is_digit;
      logic [MAG_WIDTH-1:0]   digit;
      logic [COUNT_WIDTH-1:0] cap;
      is_digit = (it.ch >= CHAR_ZERO) && (it.ch <= CHAR_NINE);
      digit = is_digit ? MAG_WIDTH'(it.ch - CHAR_ZERO) : '0;
      cap = (cfg_fraction_limit > FRACTION_CAP) ? COUNT_WIDTH'(FRACTION_CAP)
                                                : cfg_fraction_limit;
      outcome = '0;
      case (scan_phase)
         SCAN_SPACE: begin
            if (it.ch == CHAR_MINUS) begin
               minus_flag = 1'b1;
               scan_phase = SCAN_SIGN;
            end else if (it.ch == CHAR_PLUS) begin
               scan_phase = SCAN_SIGN;
            end else if (is_digit) begin
               int_total = digit;
               scan_phase = SCAN_INT;
            end else if (it.ch != CHAR_SPACE) begin
               scan_error = STATUS_NO_DIGIT;
               scan_phase = SCAN_ERROR;
            end
         end
         SCAN_SIGN: begin
            if (is_digit) begin
               int_total = digit;
               scan_phase = SCAN_INT;
            end else begin
               scan_error = STATUS_NO_DIGIT;
               scan_phase = SCAN_ERROR;
            end
         end
         SCAN_INT: begin
            if (is_digit)
               int_total = int_total * 64'd10 + digit;
            else if (it.ch == CHAR_POINT && cfg_fraction_on)
               scan_phase = SCAN_POINT;
            else
               scan_phase = SCAN_DONE;
         end
         SCAN_POINT: begin
            // The first fraction digit is required even when none is kept.
            if (is_digit) begin
               if (cap > 0) begin
                  frac_total = digit;
                  frac_digits = 1;
               end
               scan_phase = SCAN_FRAC;
            end else begin
               scan_error = STATUS_NO_FRAC;
               scan_phase = SCAN_ERROR;
            end
         end
         SCAN_FRAC: begin
            if (is_digit && frac_digits < cap) begin
               frac_total = frac_total * 64'd10 + digit;
               frac_digits = frac_digits + 1'b1;
            end else begin
               scan_phase = SCAN_DONE;
            end
         end
         default: begin
         end
      endcase
      if (!it.last)
         return 1'b0;

      // Error results carry only the status.
      case (scan_phase)
         SCAN_SPACE, SCAN_SIGN: outcome.status = STATUS_NO_DIGIT;
         SCAN_POINT:            outcome.status = STATUS_NO_FRAC;
         SCAN_ERROR:            outcome.status = scan_error;
         default: begin
            outcome.negative          = minus_flag;
            outcome.integer_magnitude = int_total;
            outcome.fraction_mantissa = frac_total;
            outcome.fraction_count    = frac_digits;
            outcome.status            = STATUS_OK;
         end
      endcase
      scan_phase  = SCAN_SPACE;
      minus_flag  = 1'b0;
      int_total   = '0;
      frac_total  = '0;
      frac_digits = '0;
      scan_error  = STATUS_OK;
      return 1'b1;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic void add_case(input bit en, input logic [COUNT_WIDTH-1:0] lim,
                                    input string text, input bit typed, input bit neg,
                                    input logic [63:0] mag, input logic [63:0] mant,
                                    input logic [COUNT_WIDTH-1:0] cnt,
                                    input logic [STATUS_WIDTH-1:0] st);
      numeral_case_type row;
      row.fraction_on              = en;
      row.fraction_limit           = lim;
      row.text                     = text;
      row.typed                    = typed;
      row.result.negative          = neg;
      row.result.integer_magnitude = mag;
      row.result.fraction_mantissa = mant;
      row.result.fraction_count    = cnt;
      row.result.status            = st;
      directed_cases.push_back(row);
   endfunction

   function automatic int draw_gap(input bit busy);
      return busy ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // Mostly well-formed numerals with random digits; the rest are cut short,
   // carry one corrupted character, or are plain noise.
   function automatic char_queue_type random_numeral();
      char_queue_type chars;
      int             kind;
      int             count;
      int             pos;
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
         count = $urandom_range(1, 5);
         repeat (count) chars.push_back(CH_WIDTH'($urandom_range(0, 255)));
         return chars;
      end
      count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (count) chars.push_back(CHAR_SPACE);
      case ($urandom_range(0, 2))
         1: chars.push_back(CHAR_MINUS);
         2: chars.push_back(CHAR_PLUS);
         default: begin
         end
      endcase
      count = ($urandom_range(0, 7) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 6);
      repeat (count) chars.push_back(CHAR_ZERO + CH_WIDTH'($urandom_range(0, 9)));
      if ($urandom_range(0, 2) != 0) begin
         chars.push_back(CHAR_POINT);
         count = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 23) : $urandom_range(1, 6);
         repeat (count) chars.push_back(CHAR_ZERO + CH_WIDTH'($urandom_range(0, 9)));
      end
      count = $urandom_range(0, 2);
      repeat (count) chars.push_back(CH_WIDTH'($urandom_range(0, 255)));
      if (kind == 7) begin
         count = $urandom_range(1, chars.size());
         while (chars.size() > count) chars.delete(chars.size() - 1);
      end else if (kind == 8) begin
         pos = $urandom_range(0, chars.size() - 1);
         chars[pos] = CH_WIDTH'($urandom_range(0, 255));
      end
      return chars;
   endfunction

   // Offers one character after a random gap and returns once it is taken.
   task automatic send_char(input bit [CH_WIDTH-1:0] c, input bit is_last);
      int gap;
      gap = draw_gap(sender_busy);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_item.ch   <= c;
      req_item.last <= is_last;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_numeral(input char_queue_type chars);
      foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
      buffers_sent++;
   endtask

   // Lets every outstanding result drain, then gives the pipeline time to empty.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_config(input bit en, input logic [COUNT_WIDTH-1:0] lim);
      wait_idle();
      csr_wen   <= 1'b1;
      csr_index <= CSR_FRACTION_ENABLE;
      csr_wdata <= CSR_DATA_WIDTH'(en);
      @(posedge clock);
      cfg_fraction_on = en;
      csr_index <= CSR_FRACTION_LIMIT;
      csr_wdata <= lim;
      @(posedge clock);
      cfg_fraction_limit = lim;
      csr_wen <= 1'b0;
      settings_used++;
   endtask

   // Predicts on every accepted item and checks every accepted result.
   always @(posedge clock) begin : monitor
      rsp_item_type     outcome;
      rsp_item_type     want;
      known_result_type known;
      if (!reset && req_valid && req_ready) begin
         if (scan_char(req_item, outcome)) begin
            if (known_results.size() != 0) begin
               known = known_results.pop_front();
               if (known.typed)
                  outcome = known.result;
            end
            expected_results.push_back(outcome);
         end
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result item arrived with no result expected");
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("negative", want.negative, rsp_item.negative);
            check_field("integer_magnitude", want.integer_magnitude,
                        rsp_item.integer_magnitude);
            check_field("fraction_mantissa", want.fraction_mantissa,
                        rsp_item.fraction_mantissa);
            check_field("fraction_count", want.fraction_count, rsp_item.fraction_count);
            check_field("status", want.status, rsp_item.status);
            results_checked++;
         end
      end
   end

   // Ends the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Result side: a random stall before each item, or one long hold on request.
   initial begin : receiver
      int stall;
      forever begin
         if (long_hold_pending) begin
            stall = LONG_HOLD;
            long_hold_pending = 1'b0;
         end else begin
            stall = draw_gap(receiver_busy);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
      end
   end

   initial begin : stimulus
      numeral_case_type       row;
      known_result_type       known;
      char_queue_type         chars;
      bit                     configured;
      bit                     en;
      logic [COUNT_WIDTH-1:0] lim;
      int                     phase_index;
      int                     random_start;

      // Extremes of the integer, signs, every error path and the fraction settings.
      add_case(1, 19, "0", TYPED, 0, 0, 0, 0, STATUS_OK);
      add_case(1, 19, "18446744073709551615", TYPED, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0,
               STATUS_OK);
      add_case(1, 19, "18446744073709551616", TYPED, 0, 0, 0, 0, STATUS_OK);
      add_case(1, 19, "-42", TYPED, 1, 42, 0, 0, STATUS_OK);
      add_case(1, 19, "+7", TYPED, 0, 7, 0, 0, STATUS_OK);
      add_case(1, 19, "  3.14159", FROM_PREDICTOR, 0, 0, 0, 0, STATUS_OK);
      add_case(1, 19, "x", TYPED, 0, 0, 0, 0, STATUS_NO_DIGIT);
      add_case(1, 19, "-", TYPED, 0, 0, 0, 0, STATUS_NO_DIGIT);
      add_case(1, 19, "   ", TYPED, 0, 0, 0, 0, STATUS_NO_DIGIT);
      add_case(1, 19, "+-5", TYPED, 0, 0, 0, 0, STATUS_NO_DIGIT);
      add_case(1, 19, "12.", TYPED, 0, 0, 0, 0, STATUS_NO_FRAC);
      add_case(1, 19, "-12.a9", TYPED, 0, 0, 0, 0, STATUS_NO_FRAC);
      add_case(1, 19, "12x99", FROM_PREDICTOR, 0, 0, 0, 0, STATUS_OK);
      add_case(1, 19, "0.99999999999999999999", FROM_PREDICTOR, 0, 0, 0, 0, STATUS_OK);
      add_case(1, 19, "5.25 -", FROM_PREDICTOR, 0, 0, 0, 0, STATUS_OK);
      add_case(0, 19, "3.5", FROM_PREDICTOR, 0, 0, 0, 0, STATUS_OK);
      add_case(0, 19, ".5", TYPED, 0, 0, 0, 0, STATUS_NO_DIGIT);
      add_case(1, 0, "7.25", FROM_PREDICTOR, 0, 0, 0, 0, STATUS_OK);
      add_case(1, 0, "7.", TYPED, 0, 0, 0, 0, STATUS_NO_FRAC);
      add_case(1, 31, "1.2345678901234567890123", FROM_PREDICTOR, 0, 0, 0, 0, STATUS_OK);
      add_case(1, 3, "-1.23456", FROM_PREDICTOR, 0, 0, 0, 0, STATUS_OK);
      add_case(1, 19, "9", TYPED, 0, 9, 0, 0, STATUS_OK);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed table, rewriting the registers wherever a row changes them.
      configured = 1'b0;
      foreach (directed_cases[i]) begin
         row = directed_cases[i];
         if (!configured || row.fraction_on != cfg_fraction_on ||
             row.fraction_limit != cfg_fraction_limit) begin
            apply_config(row.fraction_on, row.fraction_limit);
            configured = 1'b1;
         end
         known.typed  = row.typed;
         known.result = row.result;
         known_results.push_back(known);
         chars.delete();
         for (int k = 0; k < row.text.len(); k++) chars.push_back(row.text[k]);
         send_numeral(chars);
      end

      // Random phases, each under its own settings and idling pattern.
      phase_index  = 0;
      random_start = chars_sent;
      while (chars_sent - random_start < RANDOM_ITEMS) begin
         case (phase_index % 5)
            0:       lim = 0;
            1:       lim = 19;
            2:       lim = 31;
            3:       lim = 1;
            default: lim = COUNT_WIDTH'($urandom_range(0, 31));
         endcase
         en = (phase_index % 3) != 1;
         apply_config(en, lim);
         sender_busy   = ($urandom_range(0, 3) == 0);
         receiver_busy = ($urandom_range(0, 3) == 0);
         // One phase keeps the sender going while the receiver holds off.
         if (phase_index == 2) begin
            sender_busy       = 1'b1;
            long_hold_pending = 1'b1;
         end
         repeat ($urandom_range(4, 10)) send_numeral(random_numeral());
         phase_index++;
      end

      wait_idle();
      $display("Sent %0d characters in %0d buffers and checked %0d results.",
               chars_sent, buffers_sent, results_checked);
      $display("Used %0d register settings, with one long result-side hold.", settings_used);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
